[rtl/core/homogeneous_line_clipper_assert.svh]
// Assertion macros used by the port-level clipper checker.
`ifndef HOMOGENEOUS_LINE_CLIPPER_ASSERT_SVH
`define HOMOGENEOUS_LINE_CLIPPER_ASSERT_SVH
// same-cycle implication, disabled in reset
`define HLC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");
// next-cycle implication, disabled in reset
`define HLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");
`endif

[rtl/core/hlc_pkg.sv]
// Types, constants and helpers of the homogeneous line clipper.
package hlc_pkg;
	localparam int COORD_BITS = 32;
	localparam int T_SHIFT    = 16;
	localparam int T_W        = T_SHIFT + 1;
	localparam int D_W        = COORD_BITS + 1;
	localparam int M_W        = COORD_BITS + 1;
	localparam int DEN_W      = COORD_BITS + 2;
	localparam int Q_W        = T_W + 1;
	localparam int REM_W      = DEN_W + T_W + 1;
	localparam int DIV_STAGES = Q_W / 2;
	localparam int N_PLANES   = 6;
	localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_W  = 8 * COORD_BITS + 2 * T_W;
	localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_SHIFT;

	localparam int IX = 0;
	localparam int IY = 1;
	localparam int IZ = 2;
	localparam int IW = 3;

	localparam logic [1:0] ST_KEEP = 2'd0;
	localparam logic [1:0] ST_CLIP = 2'd1;
	localparam logic [1:0] ST_DISC = 2'd2;

	typedef enum logic [2:0] {
		PL_NEAR   = 3'd0,
		PL_FAR    = 3'd1,
		PL_LEFT   = 3'd2,
		PL_RIGHT  = 3'd3,
		PL_TOP    = 3'd4,
		PL_BOTTOM = 3'd5
	} plane_t;

	// element 0 is x, in the lowest bits
	typedef logic [3:0][COORD_BITS-1:0] vec_t;

	typedef struct packed {
		vec_t           a;
		vec_t           b;
		logic [T_W-1:0] pa;
		logic [T_W-1:0] pb;
		logic           disc;
		logic           clip;
	} seg_t;

	typedef struct packed {
		seg_t             seg;
		logic             act;
		logic             mv_b;
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] dsh;
		logic [Q_W-1:0]   q;
	} div_t;

	function automatic logic signed [D_W-1:0] ext(input logic [COORD_BITS-1:0] c);
		ext = D_W'(signed'(c));
	endfunction

	function automatic logic signed [D_W-1:0] plane_dist(input vec_t p, input plane_t pl);
		unique case (pl)
			PL_NEAR:   plane_dist = ext(p[IZ]) + ext(p[IW]);
			PL_FAR:    plane_dist = ext(p[IW]) - ext(p[IZ]);
			PL_LEFT:   plane_dist = ext(p[IX]) + ext(p[IW]);
			PL_RIGHT:  plane_dist = ext(p[IW]) - ext(p[IX]);
			PL_TOP:    plane_dist = ext(p[IW]) - ext(p[IY]);
			PL_BOTTOM: plane_dist = ext(p[IY]) + ext(p[IW]);
			default:   plane_dist = '0;
		endcase
	endfunction
endpackage

[rtl/core/homogeneous_line_clipper.sv]
// Top level of the homogeneous clip-space line clipper.
// Input channel s_*: one line segment per item, two clip-space endpoints
// (x, y, z, w) in signed Q16.16. Output channel m_*: one result per item,
// the clipped endpoints, their positions on the original segment in Q1.16,
// and the status in m_tuser (kept, clipped, discarded).
// Planes are applied in order near, far, left, right, top, bottom; each
// plane is a distance stage, nine divider stages of two quotient bits and a
// multiply stage followed by a round/saturate stage.
// Throughput: one item per cycle while the receiver does not stall, set by
// the fully pipelined per-plane divider and multipliers.
// Reset clears every stage valid bit; no item is in flight afterwards.
// When the receiver stalls, each stage holds its item and empty stages in
// front of it keep filling, so s_tready drops only once the whole pipe is
// full; nothing is lost or repeated.
module homogeneous_line_clipper (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w
	input  logic [hlc_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_start_x..w, out_end_x..w, param_start, param_end, zero pad
	output logic [hlc_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic [1:0]                m_tuser
);
	hlc_pkg::seg_t seg_d   [hlc_pkg::N_PLANES+1];
	logic          seg_vld [hlc_pkg::N_PLANES+1];
	logic          seg_rdy [hlc_pkg::N_PLANES+1];
	hlc_pkg::div_t div_d   [hlc_pkg::N_PLANES][hlc_pkg::DIV_STAGES+1];
	logic          div_vld [hlc_pkg::N_PLANES][hlc_pkg::DIV_STAGES+1];
	logic          div_rdy [hlc_pkg::N_PLANES][hlc_pkg::DIV_STAGES+1];
	hlc_pkg::seg_t res;

	always_comb begin
		seg_d[0].a    = s_tdata[4*hlc_pkg::COORD_BITS-1:0];
		seg_d[0].b    = s_tdata[8*hlc_pkg::COORD_BITS-1:4*hlc_pkg::COORD_BITS];
		seg_d[0].pa   = '0;
		seg_d[0].pb   = hlc_pkg::T_ONE;
		seg_d[0].disc = 1'b0;
		seg_d[0].clip = 1'b0;
	end
	assign seg_vld[0] = s_tvalid;
	assign s_tready   = seg_rdy[0];

	for (genvar g = 0; g < hlc_pkg::N_PLANES; g++) begin : g_plane
		hlc_dist u_dist (
			.clk(clk), .arst_n(arst_n),
			.plane(hlc_pkg::plane_t'(g)),
			.in_valid(seg_vld[g]), .in_ready(seg_rdy[g]), .in_seg(seg_d[g]),
			.out_valid(div_vld[g][0]), .out_ready(div_rdy[g][0]), .out_div(div_d[g][0])
		);
		for (genvar k = 0; k < hlc_pkg::DIV_STAGES; k++) begin : g_div
			hlc_div_stage u_div (
				.clk(clk), .arst_n(arst_n),
				.in_valid(div_vld[g][k]), .in_ready(div_rdy[g][k]), .in_div(div_d[g][k]),
				.out_valid(div_vld[g][k+1]), .out_ready(div_rdy[g][k+1]),
				.out_div(div_d[g][k+1])
			);
		end
		hlc_interp u_interp (
			.clk(clk), .arst_n(arst_n),
			.in_valid(div_vld[g][hlc_pkg::DIV_STAGES]),
			.in_ready(div_rdy[g][hlc_pkg::DIV_STAGES]),
			.in_div(div_d[g][hlc_pkg::DIV_STAGES]),
			.out_valid(seg_vld[g+1]), .out_ready(seg_rdy[g+1]), .out_seg(seg_d[g+1])
		);
	end

	assign res                          = seg_d[hlc_pkg::N_PLANES];
	assign m_tvalid                     = seg_vld[hlc_pkg::N_PLANES];
	assign seg_rdy[hlc_pkg::N_PLANES]   = m_tready;

	always_comb begin
		if (res.disc) begin
			m_tdata = '0;
			m_tuser = hlc_pkg::ST_DISC;
		end else begin
			m_tdata = hlc_pkg::OUT_W'({res.pb, res.pa, res.b, res.a});
			m_tuser = res.clip ? hlc_pkg::ST_CLIP : hlc_pkg::ST_KEEP;
		end
	end
endmodule

[rtl/core/hlc_dist.sv]
// Plane distance, classification and divider setup stage.
module hlc_dist (
	input  logic            clk,
	input  logic            arst_n,
	input  hlc_pkg::plane_t plane,
	input  logic            in_valid,
	output logic            in_ready,
	input  hlc_pkg::seg_t   in_seg,
	output logic            out_valid,
	input  logic            out_ready,
	output hlc_pkg::div_t   out_div
);
	logic signed [hlc_pkg::D_W-1:0] d0, d1;
	logic [hlc_pkg::M_W-1:0]        n0, n1;
	logic [hlc_pkg::DEN_W-1:0]      den;
	hlc_pkg::div_t                  nxt;
	logic                           vld_s1;
	hlc_pkg::div_t                  div_s1;

	always_comb begin
		d0  = hlc_pkg::plane_dist(in_seg.a, plane);
		d1  = hlc_pkg::plane_dist(in_seg.b, plane);
		n0  = d0[hlc_pkg::D_W-1] ? hlc_pkg::M_W'(unsigned'(-d0)) : hlc_pkg::M_W'(unsigned'(d0));
		n1  = d1[hlc_pkg::D_W-1] ? hlc_pkg::M_W'(unsigned'(-d1)) : hlc_pkg::M_W'(unsigned'(d1));
		den = hlc_pkg::DEN_W'(n0) + hlc_pkg::DEN_W'(n1);
		nxt.seg  = in_seg;
		nxt.seg.disc = in_seg.disc | (d0[hlc_pkg::D_W-1] & d1[hlc_pkg::D_W-1]);
		nxt.act  = !in_seg.disc && (d0[hlc_pkg::D_W-1] != d1[hlc_pkg::D_W-1]);
		nxt.mv_b = !d0[hlc_pkg::D_W-1];
		nxt.rem  = (hlc_pkg::REM_W'(n0) << hlc_pkg::T_W) + hlc_pkg::REM_W'(den);
		nxt.dsh  = hlc_pkg::REM_W'(den) << (hlc_pkg::T_W + 1);
		nxt.q    = '0;
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			div_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_div   = div_s1;
endmodule

[rtl/core/hlc_div_stage.sv]
// Two restoring division steps of the clip parameter divider.
module hlc_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hlc_pkg::div_t in_div,
	output logic          out_valid,
	input  logic          out_ready,
	output hlc_pkg::div_t out_div
);
	hlc_pkg::div_t nxt;
	logic          vld_s1;
	hlc_pkg::div_t div_s1;

	always_comb begin
		nxt = in_div;
		for (int k = 0; k < 2; k++) begin
			if (nxt.rem >= nxt.dsh) begin
				nxt.rem = nxt.rem - nxt.dsh;
				nxt.q   = {nxt.q[hlc_pkg::Q_W-2:0], 1'b1};
			end else begin
				nxt.q   = {nxt.q[hlc_pkg::Q_W-2:0], 1'b0};
			end
			nxt.dsh = nxt.dsh >> 1;
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			div_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_div   = div_s1;
endmodule

[rtl/core/hlc_interp.sv]
// Endpoint move: multiply stage, then round, add and saturate stage.
module hlc_interp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hlc_pkg::div_t in_div,
	output logic          out_valid,
	input  logic          out_ready,
	output hlc_pkg::seg_t out_seg
);
	localparam int P_W  = hlc_pkg::D_W + hlc_pkg::T_W + 1;
	localparam int PP_W = 2 * (hlc_pkg::T_W + 1);
	localparam logic signed [P_W-1:0] C_MAX =
		signed'(P_W'({1'b0, {(hlc_pkg::COORD_BITS-1){1'b1}}}));
	localparam logic signed [P_W-1:0] C_MIN = ~C_MAX;

	typedef struct packed {
		hlc_pkg::seg_t            seg;
		logic                     act;
		logic                     mv_b;
		logic [3:0][P_W-1:0]      prod;
		logic [PP_W-1:0]          pprod;
	} mul_t;

	logic [hlc_pkg::T_W-1:0]        t;
	logic signed [hlc_pkg::D_W-1:0] diff;
	logic signed [hlc_pkg::T_W:0]   pdiff;
	mul_t                           mnxt;
	hlc_pkg::seg_t                  snxt;
	hlc_pkg::vec_t                  mv;
	logic [hlc_pkg::T_W-1:0]        pmv;
	logic signed [P_W-1:0]          sum;
	logic signed [PP_W-1:0]         psum;
	logic                           vld_s1, vld_s2, rdy_s2;
	mul_t                           mul_s1;
	hlc_pkg::seg_t                  seg_s2;

	always_comb begin
		t = (in_div.q > hlc_pkg::Q_W'(hlc_pkg::T_ONE)) ? hlc_pkg::T_ONE
			: in_div.q[hlc_pkg::T_W-1:0];
		mnxt.seg  = in_div.seg;
		mnxt.act  = in_div.act;
		mnxt.mv_b = in_div.mv_b;
		for (int i = 0; i < 4; i++) begin
			diff = hlc_pkg::ext(in_div.seg.b[i]) - hlc_pkg::ext(in_div.seg.a[i]);
			mnxt.prod[i] = P_W'(P_W'(diff) * P_W'(signed'({1'b0, t})));
		end
		pdiff = signed'({1'b0, in_div.seg.pb}) - signed'({1'b0, in_div.seg.pa});
		mnxt.pprod = PP_W'(PP_W'(pdiff) * PP_W'(signed'({1'b0, t})));
	end

	always_comb begin
		snxt = mul_s1.seg;
		for (int i = 0; i < 4; i++) begin
			sum = P_W'(signed'(mul_s1.seg.a[i]))
				+ ((signed'(mul_s1.prod[i]) + P_W'(1 << (hlc_pkg::T_SHIFT - 1)))
				>>> hlc_pkg::T_SHIFT);
			if (sum > C_MAX)
				mv[i] = C_MAX[hlc_pkg::COORD_BITS-1:0];
			else if (sum < C_MIN)
				mv[i] = C_MIN[hlc_pkg::COORD_BITS-1:0];
			else
				mv[i] = sum[hlc_pkg::COORD_BITS-1:0];
		end
		psum = PP_W'(mul_s1.seg.pa)
			+ ((signed'(mul_s1.pprod) + PP_W'(1 << (hlc_pkg::T_SHIFT - 1))) >>> hlc_pkg::T_SHIFT);
		pmv = psum[hlc_pkg::T_W-1:0];
		if (mul_s1.act) begin
			if (mul_s1.mv_b) begin
				snxt.b  = mv;
				snxt.pb = pmv;
			end else begin
				snxt.a  = mv;
				snxt.pa = pmv;
			end
			snxt.clip = 1'b1;
		end
	end

	assign rdy_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (rdy_s2)   vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) mul_s1 <= mnxt;
		if (rdy_s2)   seg_s2 <= snxt;
	end

	assign out_valid = vld_s2;
	assign out_seg   = seg_s2;
endmodule

[rtl/core/hlc_checker.sv]
// Port-level checker of the line clipper and its bind.
`include "homogeneous_line_clipper_assert.svh"
module hlc_props (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [hlc_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                m_tuser
);
	logic [hlc_pkg::T_W-1:0] p_start, p_end;
	logic                    out_stall, out_keep, out_clip, out_disc;
	logic                    status_ok, keep_ok, order_ok;

	assign p_start = m_tdata[8*hlc_pkg::COORD_BITS+hlc_pkg::T_W-1:8*hlc_pkg::COORD_BITS];
	assign p_end   = m_tdata[8*hlc_pkg::COORD_BITS+2*hlc_pkg::T_W-1:
		8*hlc_pkg::COORD_BITS+hlc_pkg::T_W];

	assign out_stall = m_tvalid && !m_tready;
	assign out_keep  = m_tvalid && m_tuser == hlc_pkg::ST_KEEP;
	assign out_clip  = m_tvalid && m_tuser == hlc_pkg::ST_CLIP;
	assign out_disc  = m_tvalid && m_tuser == hlc_pkg::ST_DISC;
	assign status_ok = m_tuser == hlc_pkg::ST_KEEP || m_tuser == hlc_pkg::ST_CLIP
		|| m_tuser == hlc_pkg::ST_DISC;
	assign keep_ok   = p_start == '0 && p_end == hlc_pkg::T_ONE;
	assign order_ok  = p_start <= p_end && p_end <= hlc_pkg::T_ONE;

	`HLC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`HLC_ASSERT_IMPL(a_status_code, m_tvalid, status_ok)
	`HLC_ASSERT_IMPL(a_disc_zero, out_disc, m_tdata == '0)
	`HLC_ASSERT_IMPL(a_keep_params, out_keep, keep_ok)
	`HLC_ASSERT_IMPL(a_param_order, out_clip, order_ok)
endmodule

bind homogeneous_line_clipper hlc_props u_hlc_props (.*);

[verif/hlc_checker.sv]
// Checker for the line clipper: predicts each result and compares it.
`timescale 1ns / 1ps
module hlc_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [hlc_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [hlc_pkg::OUT_W-1:0] m_tdata,
	input  logic [1:0]                m_tuser,
	output int                        errors,
	output int                        pending
);
	typedef struct packed {
		logic [1:0]              status;
		hlc_pkg::vec_t           a;
		hlc_pkg::vec_t           b;
		logic [hlc_pkg::T_W-1:0] pa;
		logic [hlc_pkg::T_W-1:0] pb;
	} clip_res_t;

	clip_res_t clip_q[$];

	function automatic longint dist_of(longint p[4], hlc_pkg::plane_t pl);
		case (pl)
			hlc_pkg::PL_NEAR:  dist_of = p[hlc_pkg::IZ] + p[hlc_pkg::IW];
			hlc_pkg::PL_FAR:   dist_of = p[hlc_pkg::IW] - p[hlc_pkg::IZ];
			hlc_pkg::PL_LEFT:  dist_of = p[hlc_pkg::IX] + p[hlc_pkg::IW];
			hlc_pkg::PL_RIGHT: dist_of = p[hlc_pkg::IW] - p[hlc_pkg::IX];
			hlc_pkg::PL_TOP:   dist_of = p[hlc_pkg::IW] - p[hlc_pkg::IY];
			default:           dist_of = p[hlc_pkg::IY] + p[hlc_pkg::IW];
		endcase
	endfunction

	function automatic longint rnd16(longint v);
		longint s;
		s = v + 32768;
		if (s >= 0)
			rnd16 = s >>> 16;
		else
			rnd16 = -((-s + 65535) >>> 16);
	endfunction

	function automatic longint lerp(longint a, longint b, longint t);
		lerp = a + rnd16((b - a) * t);
	endfunction

	function automatic longint sat(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (hlc_pkg::COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		sat = v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic clip_res_t clip_line(logic [hlc_pkg::IN_W-1:0] d);
		longint a[4], b[4];
		longint pa, pb, d0, d1, n0, den, t;
		bit cl;
		clip_res_t r;
		pa = 0;
		pb = 65536;
		cl = 0;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'(signed'(d[i*hlc_pkg::COORD_BITS +: hlc_pkg::COORD_BITS]));
			b[i] = longint'(signed'(d[(4+i)*hlc_pkg::COORD_BITS +: hlc_pkg::COORD_BITS]));
		end
		for (int p = 0; p < hlc_pkg::N_PLANES; p++) begin
			d0 = dist_of(a, hlc_pkg::plane_t'(p));
			d1 = dist_of(b, hlc_pkg::plane_t'(p));
			if (d0 < 0 && d1 < 0) begin
				r.status = hlc_pkg::ST_DISC;
				return r;
			end
			if (d0 < 0 || d1 < 0) begin
				n0 = d0 < 0 ? -d0 : d0;
				den = n0 + (d1 < 0 ? -d1 : d1);
				t = (n0 * 131072 + den) / (2 * den);
				if (t > 65536) t = 65536;
				if (d0 >= 0) begin
					for (int i = 0; i < 4; i++) b[i] = sat(lerp(a[i], b[i], t));
					pb = lerp(pa, pb, t);
				end else begin
					for (int i = 0; i < 4; i++) a[i] = sat(lerp(a[i], b[i], t));
					pa = lerp(pa, pb, t);
				end
				cl = 1;
			end
		end
		r.status = cl ? hlc_pkg::ST_CLIP : hlc_pkg::ST_KEEP;
		for (int i = 0; i < 4; i++) begin
			r.a[i] = a[i][hlc_pkg::COORD_BITS-1:0];
			r.b[i] = b[i][hlc_pkg::COORD_BITS-1:0];
		end
		r.pa = pa[hlc_pkg::T_W-1:0];
		r.pb = pb[hlc_pkg::T_W-1:0];
		return r;
	endfunction

	assign pending = clip_q.size();

	always @(posedge clk or negedge arst_n) begin
		clip_res_t e, g;
		if (!arst_n) begin
			errors <= 0;
			clip_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				g.status = m_tuser;
				g.a = m_tdata[0 +: 4*hlc_pkg::COORD_BITS];
				g.b = m_tdata[4*hlc_pkg::COORD_BITS +: 4*hlc_pkg::COORD_BITS];
				g.pa = m_tdata[8*hlc_pkg::COORD_BITS +: hlc_pkg::T_W];
				g.pb = m_tdata[8*hlc_pkg::COORD_BITS+hlc_pkg::T_W +: hlc_pkg::T_W];
				if (clip_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, g);
					errors <= errors + 1;
				end else begin
					e = clip_q.pop_front();
					if (e.status !== g.status || e.a !== g.a || e.b !== g.b ||
							e.pa !== g.pa || e.pb !== g.pb) begin
						$display("%0t: mismatch status exp %0d got %0d", $time,
							e.status, g.status);
						$display("  a exp %h got %h / b exp %h got %h", e.a, g.a, e.b, g.b);
						$display("  pa exp %h got %h / pb exp %h got %h", e.pa, g.pa,
							e.pb, g.pb);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				clip_q.push_back(clip_line(s_tdata));
		end
	end
endmodule

[verif/tb.sv]
// Testbench top for the line clipper: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb;
	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [hlc_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [hlc_pkg::OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;
	int quiet = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	homogeneous_line_clipper u_dut (.*);
	hlc_checker u_chk (.*);

	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic logic [hlc_pkg::COORD_BITS-1:0] rnd_coord(int w);
		logic [hlc_pkg::COORD_BITS-1:0] v;
		case ($urandom_range(9))
			0: v = {1'b1, {(hlc_pkg::COORD_BITS-1){1'b0}}};
			1: v = {1'b0, {(hlc_pkg::COORD_BITS-1){1'b1}}};
			2: v = $urandom;
			3: v = '0;
			default: v = hlc_pkg::COORD_BITS'(signed'($urandom_range(2*w) - w)) <<< 8;
		endcase
		return v;
	endfunction

	// mostly lines near the view volume so that clipping happens
	function automatic logic [hlc_pkg::IN_W-1:0] rnd_line();
		logic [hlc_pkg::IN_W-1:0] d;
		int sc;
		sc = 1 << $urandom_range(20);
		for (int i = 0; i < 8; i++) begin
			if (i % 4 == hlc_pkg::IW && $urandom_range(3) != 0)
				d[i*hlc_pkg::COORD_BITS +: hlc_pkg::COORD_BITS] =
					hlc_pkg::COORD_BITS'($urandom_range(sc)) <<< 8;
			else
				d[i*hlc_pkg::COORD_BITS +: hlc_pkg::COORD_BITS] = rnd_coord(sc);
		end
		return d;
	endfunction

	task automatic send(logic [hlc_pkg::IN_W-1:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [hlc_pkg::IN_W-1:0] mk(int sx, sy, sz, sw, ex, ey, ez, ew);
		logic [hlc_pkg::IN_W-1:0] d;
		int v[8];
		v = '{sx, sy, sz, sw, ex, ey, ez, ew};
		for (int i = 0; i < 8; i++)
			d[i*hlc_pkg::COORD_BITS +: hlc_pkg::COORD_BITS] = hlc_pkg::COORD_BITS'(v[i]);
		return d;
	endfunction

	initial begin
		int one;
		one = 65536;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(mk(0, 0, 0, one, one/2, 0, 0, one));
		send(mk(0, 0, -2*one, one, 0, 0, 0, one));
		send(mk(0, 0, 0, one, 0, 0, 2*one, one));
		send(mk(-2*one, 0, 0, one, 0, 0, 0, one));
		send(mk(0, 0, 0, one, 2*one, 0, 0, one));
		send(mk(0, 2*one, 0, one, 0, 0, 0, one));
		send(mk(0, 0, 0, one, 0, -2*one, 0, one));
		send(mk(3*one, 0, 0, one, 2*one, 0, 0, one));
		send(mk(-one, 0, 0, one, 2*one, 0, 0, one));
		send(mk(-2*one, -2*one, -2*one, one, 2*one, 2*one, 2*one, one));
		send(mk(0, 0, -one, one, 0, 0, -3*one, one));
		send(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send({hlc_pkg::IN_W{1'b1}});
		send({8{32'h80000000}});
		send({8{32'h7fffffff}});
		send({4{32'h7fffffff, 32'h80000000}});
		send({4{32'h80000000, 32'h7fffffff}});
		send(mk(int'(32'h80000000), 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0,
			int'(32'h80000000)));
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 23) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 23) : 0;
			if (ph == 0) begin
				hold_off <= 1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off <= 0;
					end
				join_none
			end
			for (int k = 0; k < 458; k++) send(rnd_line());
		end
		s_tvalid <= 0;
		send_idle = 0;
		recv_stall = 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
